// ===== src/prbc_pkg.sv =====
// Shared widths, codes and payload types of the partition bounds checker.
package prbc_pkg;

	localparam int START_W   = 32;
	localparam int BYTES_W   = 24;
	localparam int OFF_W     = 32;
	localparam int BPS_W     = 7;
	localparam int SPC_W     = 24;
	localparam int CYL_W     = 32;
	localparam int VERDICT_W = 2;

	localparam int BLOCK_SHIFT  = 9;
	localparam int LABEL_SECTOR = 1;
	localparam int BLK_MASK     = (1 << BLOCK_SHIFT) - 1;

	localparam int SCALED_W  = OFF_W + BPS_W;
	localparam int ABS_W     = SCALED_W + 1;
	localparam int END_W     = ABS_W + 1;
	localparam int LEN_W     = BYTES_W - BLOCK_SHIFT + 1;
	localparam int TRUNC_W   = BYTES_W - BLOCK_SHIFT;
	localparam int DIV_STEPS = ABS_W;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int IDX_W  = 2;

	localparam logic [IDX_W-1:0] REG_BPS = 2'd0;
	localparam logic [IDX_W-1:0] REG_SPC = 2'd1;
	localparam logic [IDX_W-1:0] REG_RAW = 2'd2;

	localparam logic [BPS_W-1:0] BPS_RESET = 7'd1;

	localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT  = 2'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_EOP     = 2'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_INVALID = 2'd2;
	localparam logic [VERDICT_W-1:0] VERDICT_REFUSED = 2'd3;

	typedef struct packed {
		logic [START_W-1:0] start_block;
		logic [BYTES_W-1:0] byte_count;
		logic               is_read;
		logic               label_write_enabled;
		logic [OFF_W-1:0]   partition_offset;
		logic [OFF_W-1:0]   partition_size;
	} req_t;

	typedef struct packed {
		logic [BPS_W-1:0] blocks_per_sector;
		logic [SPC_W-1:0] sectors_per_cylinder;
		logic [OFF_W-1:0] raw_partition_offset;
	} cfg_t;

	typedef struct packed {
		logic [VERDICT_W-1:0] verdict;
		logic [BYTES_W-1:0]   adjusted;
		logic [BYTES_W-1:0]   resid;
	} side_t;

	typedef struct packed {
		logic [SPC_W-1:0] rem;
		logic [ABS_W-1:0] quo;
		side_t            side;
	} cell_t;

endpackage

// ===== src/prbc_req_if.sv =====
// Request channel: valid/ready handshake with the request fields.
interface prbc_req_if;
	logic                          valid;
	logic                          ready;
	logic [prbc_pkg::START_W-1:0]  start_block;
	logic [prbc_pkg::BYTES_W-1:0]  byte_count;
	logic                          is_read;
	logic                          label_write_enabled;
	logic [prbc_pkg::OFF_W-1:0]    partition_offset;
	logic [prbc_pkg::OFF_W-1:0]    partition_size;

	modport source (output valid, start_block, byte_count, is_read, label_write_enabled,
		partition_offset, partition_size, input ready);
	modport sink (input valid, start_block, byte_count, is_read, label_write_enabled,
		partition_offset, partition_size, output ready);
endinterface

// ===== src/prbc_rsp_if.sv =====
// Result channel: valid/ready handshake with the verdict fields.
interface prbc_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [prbc_pkg::VERDICT_W-1:0] verdict;
	logic [prbc_pkg::BYTES_W-1:0]   adjusted_byte_count;
	logic [prbc_pkg::BYTES_W-1:0]   residual_bytes;
	logic [prbc_pkg::CYL_W-1:0]     cylinder;

	modport source (output valid, verdict, adjusted_byte_count, residual_bytes, cylinder,
		input ready);
	modport sink (input valid, verdict, adjusted_byte_count, residual_bytes, cylinder,
		output ready);
endinterface

// ===== src/partition_request_bounds_check.sv =====
// Top level: APB registers, input skid, check stages, divider chain, output register.
// Path from the accepting edge to the result beat: 3 check stages, one divider cell
// per bit of the 40-bit absolute block, one output register.
// Throughput: one request beat per cycle while rsp is not stalled; the 40-cell
// cylinder divider chain holds one request per cell. The input skid holds one beat
// taken in a stall. Reset clears all valid bits and sets the registers to 1, 0, 0.
module partition_request_bounds_check (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [prbc_pkg::ADDR_W-1:0]   paddr,
	input  logic [prbc_pkg::DATA_W-1:0]   pwdata,
	output logic [prbc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	prbc_req_if.sink                      req,
	prbc_rsp_if.source                    rsp
);

	localparam int DIV_STEPS = prbc_pkg::DIV_STEPS;

	prbc_pkg::cfg_t   cfg;
	prbc_pkg::req_t   in_req;
	prbc_pkg::req_t   skid_q;
	prbc_pkg::req_t   feed;
	logic             skid_valid_q;
	logic             feed_valid;
	logic             adv;
	logic             out_valid_q;
	prbc_pkg::cell_t  out_q;

	prbc_pkg::cell_t  chain [DIV_STEPS+1];
	logic             chain_v [DIV_STEPS+1];

	prbc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign in_req.start_block         = req.start_block;
	assign in_req.byte_count          = req.byte_count;
	assign in_req.is_read             = req.is_read;
	assign in_req.label_write_enabled = req.label_write_enabled;
	assign in_req.partition_offset    = req.partition_offset;
	assign in_req.partition_size      = req.partition_size;

	assign adv        = !out_valid_q || rsp.ready;
	assign req.ready  = !skid_valid_q;
	assign feed_valid = skid_valid_q || req.valid;
	assign feed       = skid_valid_q ? skid_q : in_req;

	// skid holds a beat taken while the pipeline is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
		end else if (adv) begin
			skid_valid_q <= 1'b0;
		end else if (req.valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!adv && req.valid && !skid_valid_q) begin
			skid_q <= in_req;
		end
	end

	prbc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (feed_valid),
		.in_req    (feed),
		.cfg       (cfg),
		.out_valid (chain_v[0]),
		.out_cell  (chain[0])
	);

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		prbc_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.divisor   (cfg.sectors_per_cylinder),
			.in_valid  (chain_v[i]),
			.in_cell   (chain[i]),
			.out_valid (chain_v[i+1]),
			.out_cell  (chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= chain_v[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= chain[DIV_STEPS];
		end
	end

	assign rsp.valid               = out_valid_q;
	assign rsp.verdict             = out_q.side.verdict;
	assign rsp.adjusted_byte_count = out_q.side.adjusted;
	assign rsp.residual_bytes      = out_q.side.resid;
	assign rsp.cylinder            = (out_q.side.verdict == prbc_pkg::VERDICT_ACCEPT)
		? out_q.quo[prbc_pkg::CYL_W-1:0] : '0;

	a_cyl_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.verdict != prbc_pkg::VERDICT_ACCEPT |-> rsp.cylinder == '0)
		else $error("cylinder nonzero on a non-accepted verdict");

	a_resid_eop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.verdict != prbc_pkg::VERDICT_EOP |-> rsp.residual_bytes == '0)
		else $error("residual nonzero outside end of partition");

	a_eop_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.verdict == prbc_pkg::VERDICT_EOP
		|-> rsp.adjusted_byte_count == rsp.residual_bytes)
		else $error("end of partition beat with adjusted count differing from residual");

	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && !adv |=> skid_valid_q)
		else $error("skid beat dropped during stall");

	a_chain_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && chain_v[DIV_STEPS] |=> rsp.valid)
		else $error("divider output beat not presented");

endmodule

// ===== src/prbc_cfg.sv =====
// APB register file for block factor, geometry and raw partition offset.
module prbc_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [prbc_pkg::ADDR_W-1:0]   paddr,
	input  logic [prbc_pkg::DATA_W-1:0]   pwdata,
	output logic [prbc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output prbc_pkg::cfg_t                cfg
);

	prbc_pkg::cfg_t                 cfg_q;
	logic                           wr_en;
	logic [prbc_pkg::IDX_W-1:0]     idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[prbc_pkg::ADDR_W-1:prbc_pkg::ADDR_W-prbc_pkg::IDX_W];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blocks_per_sector    <= prbc_pkg::BPS_RESET;
			cfg_q.sectors_per_cylinder <= '0;
			cfg_q.raw_partition_offset <= '0;
		end else if (wr_en) begin
			case (idx)
				prbc_pkg::REG_BPS: begin
					cfg_q.blocks_per_sector <= pwdata[prbc_pkg::BPS_W-1:0];
				end
				prbc_pkg::REG_SPC: begin
					cfg_q.sectors_per_cylinder <= pwdata[prbc_pkg::SPC_W-1:0];
				end
				prbc_pkg::REG_RAW: begin
					cfg_q.raw_partition_offset <= pwdata[prbc_pkg::OFF_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			prbc_pkg::REG_BPS: prdata = prbc_pkg::DATA_W'(cfg_q.blocks_per_sector);
			prbc_pkg::REG_SPC: prdata = prbc_pkg::DATA_W'(cfg_q.sectors_per_cylinder);
			prbc_pkg::REG_RAW: prdata = prbc_pkg::DATA_W'(cfg_q.raw_partition_offset);
			default:           prdata = '0;
		endcase
	end

endmodule

// ===== src/prbc_front.sv =====
// Three-stage bounds check: scaling, sums and compares, verdict select.
module prbc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  prbc_pkg::req_t      in_req,
	input  prbc_pkg::cfg_t      cfg,
	output logic                out_valid,
	output prbc_pkg::cell_t     out_cell
);

	localparam int SCALED_W = prbc_pkg::SCALED_W;
	localparam int ABS_W    = prbc_pkg::ABS_W;
	localparam int END_W    = prbc_pkg::END_W;
	localparam int LEN_W    = prbc_pkg::LEN_W;
	localparam int TRUNC_W  = prbc_pkg::TRUNC_W;
	localparam int BYTES_W  = prbc_pkg::BYTES_W;
	localparam int START_W  = prbc_pkg::START_W;

	// stage 1: scaled partition numbers, label block, length in blocks
	logic                  v_s1;
	logic [START_W-1:0]    start_s1;
	logic [BYTES_W-1:0]    bytes_s1;
	logic                  rd_s1;
	logic                  wl_s1;
	logic [SCALED_W-1:0]   poff_s1;
	logic [SCALED_W-1:0]   psize_s1;
	logic [ABS_W-1:0]      label_s1;
	logic [LEN_W-1:0]      len_s1;
	logic [BYTES_W:0]      len_sum;

	assign len_sum = (BYTES_W+1)'(in_req.byte_count) + (BYTES_W+1)'(prbc_pkg::BLK_MASK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			start_s1 <= in_req.start_block;
			bytes_s1 <= in_req.byte_count;
			rd_s1    <= in_req.is_read;
			wl_s1    <= in_req.label_write_enabled;
			poff_s1  <= SCALED_W'(in_req.partition_offset) * SCALED_W'(cfg.blocks_per_sector);
			psize_s1 <= SCALED_W'(in_req.partition_size) * SCALED_W'(cfg.blocks_per_sector);
			label_s1 <= ABS_W'(SCALED_W'(cfg.raw_partition_offset)
				* SCALED_W'(cfg.blocks_per_sector)) + ABS_W'(prbc_pkg::LABEL_SECTOR);
			len_s1   <= len_sum[BYTES_W:prbc_pkg::BLOCK_SHIFT];
		end
	end

	// stage 2: absolute block, request ends, overrun tests
	logic                  v_s2;
	logic [BYTES_W-1:0]    bytes_s2;
	logic                  rd_s2;
	logic                  wl_s2;
	logic [ABS_W-1:0]      abs_s2;
	logic [ABS_W-1:0]      label_s2;
	logic [END_W-1:0]      end_a_s2;
	logic [END_W-1:0]      end_b_s2;
	logic                  over_s2;
	logic                  below_s2;
	logic                  eq_s2;
	logic [TRUNC_W-1:0]    diff_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bytes_s2 <= bytes_s1;
			rd_s2    <= rd_s1;
			wl_s2    <= wl_s1;
			abs_s2   <= ABS_W'(start_s1) + ABS_W'(poff_s1);
			label_s2 <= label_s1;
			end_a_s2 <= END_W'(start_s1) + END_W'(poff_s1) + END_W'(len_s1);
			end_b_s2 <= END_W'(psize_s1) + END_W'(poff_s1);
			over_s2  <= (ABS_W'(start_s1) + ABS_W'(len_s1)) > ABS_W'(psize_s1);
			below_s2 <= SCALED_W'(start_s1) > psize_s1;
			eq_s2    <= SCALED_W'(start_s1) == psize_s1;
			diff_s2  <= psize_s1[TRUNC_W-1:0] - start_s1[TRUNC_W-1:0];
		end
	end

	// stage 3: verdict, loaded into the head of the divider chain
	prbc_pkg::side_t       side_d;
	logic [END_W-1:0]      end_sel;
	logic                  v_s3;
	prbc_pkg::cell_t       cell_s3;

	always_comb begin
		side_d.verdict  = prbc_pkg::VERDICT_ACCEPT;
		side_d.adjusted = bytes_s2;
		side_d.resid    = '0;
		end_sel         = over_s2 ? end_b_s2 : end_a_s2;
		if (cfg.sectors_per_cylinder == '0) begin
			side_d.verdict = prbc_pkg::VERDICT_INVALID;
		end else if (over_s2 && eq_s2) begin
			side_d.verdict = prbc_pkg::VERDICT_EOP;
			side_d.resid   = bytes_s2;
		end else if (over_s2 && below_s2) begin
			side_d.verdict = prbc_pkg::VERDICT_INVALID;
		end else begin
			if (over_s2) begin
				side_d.adjusted = {diff_s2, prbc_pkg::BLOCK_SHIFT'(0)};
			end
			if (abs_s2 <= label_s2 && end_sel > END_W'(label_s2) && !rd_s2 && !wl_s2) begin
				side_d.verdict  = prbc_pkg::VERDICT_REFUSED;
				side_d.adjusted = bytes_s2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_s3.rem  <= '0;
			cell_s3.quo  <= abs_s2;
			cell_s3.side <= side_d;
		end
	end

	assign out_valid = v_s3;
	assign out_cell  = cell_s3;

endmodule

// ===== src/prbc_div_cell.sv =====
// One restoring-division cell: resolves one quotient bit and passes on.
module prbc_div_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [prbc_pkg::SPC_W-1:0]    divisor,
	input  logic                          in_valid,
	input  prbc_pkg::cell_t               in_cell,
	output logic                          out_valid,
	output prbc_pkg::cell_t               out_cell
);

	localparam int SPC_W = prbc_pkg::SPC_W;
	localparam int ABS_W = prbc_pkg::ABS_W;

	logic [SPC_W:0]   trial;
	logic [SPC_W:0]   diff;
	logic             ge;
	logic             valid_q;
	prbc_pkg::cell_t  cell_q;

	assign trial = {in_cell.rem, in_cell.quo[ABS_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign ge    = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_q.rem  <= ge ? diff[SPC_W-1:0] : trial[SPC_W-1:0];
			cell_q.quo  <= {in_cell.quo[ABS_W-2:0], ge};
			cell_q.side <= in_cell.side;
		end
	end

	assign out_valid = valid_q;
	assign out_cell  = cell_q;

endmodule
